>>> sv/nfba_pkg.sv
// Shared types and constants for the next-fit bitmap slot allocator.
package nfba_pkg;

  localparam int WORD_W     = 32;
  localparam int OFF_W      = 5;
  localparam int ACTION_W   = 1;
  localparam int REQ_SLOT_W = 11;
  localparam int GIVEN_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int USED_W     = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

>>> sv/nfba_if.sv
// Valid/ready channel interfaces for the request and result words.
interface nfba_req_if;
  logic                             valid;
  logic                             ready;
  logic [nfba_pkg::ACTION_W-1:0]    action;
  logic [nfba_pkg::REQ_SLOT_W-1:0]  slot_to_free;

  modport source (output valid, action, slot_to_free, input ready);
  modport sink   (input valid, action, slot_to_free, output ready);
endinterface

interface nfba_res_if;
  logic                           valid;
  logic                           ready;
  logic [nfba_pkg::GIVEN_W-1:0]   given_slot;
  logic [nfba_pkg::STATUS_W-1:0]  status;
  logic [nfba_pkg::USED_W-1:0]    used_count;

  modport source (output valid, given_slot, status, used_count, input ready);
  modport sink   (input valid, given_slot, status, used_count, output ready);
endinterface

>>> sv/next_fit_bitmap_slot_allocator.sv
// Next-fit bitmap slot allocator: top level with word-wide occupancy memory.
//
// Usage: each request word on req carries an action (allocate or free) and,
// for a free, the slot index. Exactly one result word leaves on res for each
// request: the granted slot, a status code and the used-slot count after the
// request. Both channels move a word when valid and ready are high together.
//
// The occupancy map lives in a memory of 32-bit words, one bit per slot, with
// a registered read port. An allocate reads words circularly from the word of
// the search hint, one word per cycle, and picks the lowest free bit; it reads
// from 1 to ceil(SLOT_COUNT/32) + 1 words, and no new request is taken until
// its result has gone to the output register. A pool-full allocate is settled
// from the count without a scan. A free reads the word, checks the bit and
// writes it back; a range error is settled without a memory read.
//
// Reset (rst, synchronous) clears the count and hint, then runs a clearing
// pass that writes zero to every map word; req stays low on ready during the
// pass. A finished result sits in an output register: while res is stalled,
// the block still accepts the next request and works on it, holding its
// result until the output register is free.
module next_fit_bitmap_slot_allocator #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  nfba_req_if.sink   req,
  nfba_res_if.source res
);

  localparam int WORDS     = (SLOT_COUNT + nfba_pkg::WORD_W - 1) / nfba_pkg::WORD_W;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int TAIL_BITS = SLOT_COUNT - (WORDS - 1) * nfba_pkg::WORD_W;
  localparam logic [nfba_pkg::WORD_W-1:0] TAIL_MASK =
    nfba_pkg::WORD_W'((64'd1 << TAIL_BITS) - 64'd1);
  localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORDS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(SLOT_COUNT);

  // Occupancy memory
  logic [nfba_pkg::WORD_W-1:0] mem [WORDS];
  logic [nfba_pkg::WORD_W-1:0] rd_data;
  logic                        rd_en;
  logic [WA_W-1:0]             rd_addr;
  logic                        wr_en;
  logic [WA_W-1:0]             wr_addr;
  logic [nfba_pkg::WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control and bookkeeping registers
  nfba_pkg::state_t  state, state_next;
  nfba_pkg::action_t act;
  logic [nfba_pkg::REQ_SLOT_W-1:0] slot_reg;
  logic [WA_W-1:0]   cur_word;
  logic              first;
  logic [SLOT_W-1:0] hint;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] res_slot;
  nfba_pkg::status_t res_status;
  logic [WA_W-1:0]   clr_addr;
  logic              out_valid;
  logic [nfba_pkg::GIVEN_W-1:0]  out_given;
  nfba_pkg::status_t             out_status;
  logic [nfba_pkg::USED_W-1:0]   out_used;

  // Scan datapath
  logic        req_fire;
  logic        in_range;
  logic [31:0] hint32;
  logic [WA_W-1:0] hint_word;
  logic [nfba_pkg::OFF_W-1:0] hint_off;
  logic [nfba_pkg::WORD_W-1:0] occ;
  logic [nfba_pkg::WORD_W-1:0] free_bits;
  logic        any_free;
  logic [nfba_pkg::OFF_W-1:0] found_bit;
  logic [WA_W-1:0] next_word;
  logic [31:0] pos32;
  logic [31:0] pos_inc;
  logic [nfba_pkg::OFF_W-1:0] free_bit;
  logic        free_ok;
  logic        out_free;

  assign req_fire  = req.valid && req.ready;
  assign in_range  = 32'(req.slot_to_free) < 32'(SLOT_COUNT);
  assign hint32    = 32'(hint);
  assign hint_word = WA_W'(hint32 >> nfba_pkg::OFF_W);
  assign hint_off  = hint32[nfba_pkg::OFF_W-1:0];
  assign out_free  = !out_valid || res.ready;

  // Treat tail bits past the last slot as taken, and on the first visit of
  // the hint word also the bits below the hint.
  always_comb begin
    occ = rd_data;
    if (cur_word == LAST_WORD) begin
      occ = occ | ~TAIL_MASK;
    end
    if (first) begin
      occ = occ | ((nfba_pkg::WORD_W'(1) << hint_off) - nfba_pkg::WORD_W'(1));
    end
  end

  assign free_bits = ~occ;
  assign any_free  = |free_bits;

  always_comb begin
    found_bit = '0;
    for (int i = nfba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found_bit = nfba_pkg::OFF_W'(i);
      end
    end
  end

  assign next_word = (cur_word == LAST_WORD) ? '0 : cur_word + WA_W'(1);
  assign pos32     = (32'(cur_word) << nfba_pkg::OFF_W) | 32'(found_bit);
  assign pos_inc   = (pos32 + 32'd1 >= 32'(SLOT_COUNT)) ? 32'd0 : pos32 + 32'd1;
  assign free_bit  = slot_reg[nfba_pkg::OFF_W-1:0];
  assign free_ok   = rd_data[free_bit];

  // Next state and memory port control
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = cur_word;
    wr_data    = rd_data;
    unique case (state)
      nfba_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_WORD) begin
          state_next = nfba_pkg::ST_IDLE;
        end
      end
      nfba_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req_fire) begin
          if (nfba_pkg::action_t'(req.action) == nfba_pkg::ACT_ALLOC) begin
            if (count == FULL_CNT) begin
              state_next = nfba_pkg::ST_RESP;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = hint_word;
              state_next = nfba_pkg::ST_SCAN;
            end
          end else begin
            if (!in_range) begin
              state_next = nfba_pkg::ST_RESP;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = WA_W'(32'(req.slot_to_free) >> nfba_pkg::OFF_W);
              state_next = nfba_pkg::ST_SCAN;
            end
          end
        end
      end
      nfba_pkg::ST_SCAN: begin
        if (act == nfba_pkg::ACT_ALLOC) begin
          if (any_free) begin
            wr_en      = 1'b1;
            wr_data    = rd_data | (nfba_pkg::WORD_W'(1) << found_bit);
            state_next = nfba_pkg::ST_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = next_word;
          end
        end else begin
          if (free_ok) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~(nfba_pkg::WORD_W'(1) << free_bit);
          end
          state_next = nfba_pkg::ST_RESP;
        end
      end
      nfba_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = nfba_pkg::ST_IDLE;
        end
      end
      default: state_next = nfba_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Bookkeeping: count, hint and clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      hint     <= '0;
      clr_addr <= '0;
    end else begin
      unique case (state)
        nfba_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + WA_W'(1);
        end
        nfba_pkg::ST_SCAN: begin
          if (act == nfba_pkg::ACT_ALLOC) begin
            if (any_free) begin
              count <= count + CNT_W'(1);
              hint  <= SLOT_W'(pos_inc);
            end
          end else if (free_ok) begin
            count <= count - CNT_W'(1);
            if (32'(slot_reg) < hint32) begin
              hint <= SLOT_W'(32'(slot_reg));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request latch and scan cursor (payload, no reset)
  always_ff @(posedge clk) begin
    if (state == nfba_pkg::ST_IDLE && req_fire) begin
      act      <= nfba_pkg::action_t'(req.action);
      slot_reg <= req.slot_to_free;
      cur_word <= rd_addr;
      first    <= 1'b1;
      res_slot <= '0;
      if (nfba_pkg::action_t'(req.action) == nfba_pkg::ACT_ALLOC) begin
        res_status <= nfba_pkg::STAT_FULL;
      end else if (!in_range) begin
        res_status <= nfba_pkg::STAT_RANGE;
      end else begin
        res_status <= nfba_pkg::STAT_DOUBLE;
      end
    end else if (state == nfba_pkg::ST_SCAN) begin
      if (act == nfba_pkg::ACT_ALLOC) begin
        if (any_free) begin
          res_slot   <= SLOT_W'(pos32);
          res_status <= nfba_pkg::STAT_OK;
        end else begin
          cur_word <= next_word;
          first    <= 1'b0;
        end
      end else if (free_ok) begin
        res_status <= nfba_pkg::STAT_OK;
      end
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == nfba_pkg::ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nfba_pkg::ST_RESP && out_free) begin
      out_given  <= nfba_pkg::GIVEN_W'(32'(res_slot));
      out_status <= res_status;
      out_used   <= nfba_pkg::USED_W'(32'(count));
    end
  end

  assign res.valid      = out_valid;
  assign res.given_slot = out_given;
  assign res.status     = out_status;
  assign res.used_count = out_used;

endmodule

>>> sv/nfba_checker.sv
// Port-level checker for the next-fit bitmap slot allocator, with its bind.
module nfba_checker #(
  parameter int SLOT_COUNT = 1024
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [nfba_pkg::GIVEN_W-1:0]    res_given_slot,
  input logic [nfba_pkg::STATUS_W-1:0]   res_status,
  input logic [nfba_pkg::USED_W-1:0]     res_used_count
);

  // Hold a stalled result word
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_given_slot) &&
      $stable(res_status) && $stable(res_used_count))
    else $error("result word changed while stalled");

  // Clearing pass keeps requests out just after reset
  a_clear_blocks: assert property (@(posedge clk)
    $past(rst) |-> !req_ready && !res_valid)
    else $error("request taken or result shown during clearing pass");

  // A full pool reports every slot in use
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == nfba_pkg::STAT_FULL |->
      res_used_count == nfba_pkg::USED_W'(SLOT_COUNT))
    else $error("pool full reported with free slots left");

  // Failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != nfba_pkg::STAT_OK |-> res_given_slot == '0)
    else $error("failed request carries a slot");

  // No result appears in the cycle after a request is taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !res_valid |=> !res_valid)
    else $error("result appeared too early");

endmodule

bind next_fit_bitmap_slot_allocator nfba_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_nfba_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_given_slot (res.given_slot),
  .res_status     (res.status),
  .res_used_count (res.used_count)
);

>>> sim/next_fit_bitmap_slot_allocator_tb.sv
// Self-checking testbench for the next-fit bitmap slot allocator.
`timescale 1ns / 1ps

module next_fit_bitmap_slot_allocator_tb;

  // Pool size under test; the port widths fit this size exactly.
  localparam int SLOTS         = 1024;
  localparam int RANDOM_WORDS  = 1280;
  localparam int DRAIN_WORDS   = 60;
  // Idle cycles with no word moving on either channel before the run is called hung.
  // The slowest step is a full wrap scan behind a long stall and a long sender
  // gap, or the clearing pass after reset; this is far above both.
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;

  logic clk;
  logic rst;

  nfba_req_if req_ch ();
  nfba_res_if res_ch ();

  next_fit_bitmap_slot_allocator #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // One expected result word.
  typedef struct {
    logic [nfba_pkg::GIVEN_W-1:0] given;
    nfba_pkg::status_t            status;
    logic [nfba_pkg::USED_W-1:0]  used;
  } grant_t;

  // Shadow of the slot map: predicts the result of every accepted request word
  // and matches result words against the oldest prediction.
  class grant_book;
    bit          taken[SLOTS];
    int unsigned in_use;
    int unsigned hint;
    grant_t      awaited[$];
    int          mismatches;

    function void note_request(nfba_pkg::action_t act,
                               logic [nfba_pkg::REQ_SLOT_W-1:0] slot);
      grant_t      g;
      int unsigned pos;
      bit          found;
      g.given  = '0;
      g.status = nfba_pkg::STAT_OK;
      found    = 1'b0;
      if (act == nfba_pkg::ACT_ALLOC) begin
        // Scan circularly from the hint; take the first free slot.
        for (int i = 0; i < SLOTS && !found; i++) begin
          pos = (hint + i) % SLOTS;
          if (!taken[pos]) begin
            found       = 1'b1;
            taken[pos]  = 1'b1;
            in_use++;
            hint        = (pos + 1) % SLOTS;
            g.given     = nfba_pkg::GIVEN_W'(pos);
          end
        end
        if (!found) g.status = nfba_pkg::STAT_FULL;
      end else if (slot >= SLOTS) begin
        g.status = nfba_pkg::STAT_RANGE;
      end else if (!taken[slot]) begin
        g.status = nfba_pkg::STAT_DOUBLE;
      end else begin
        taken[slot] = 1'b0;
        in_use--;
        if (slot < hint) hint = slot;
      end
      g.used = nfba_pkg::USED_W'(in_use);
      awaited.push_back(g);
    endfunction

    function void check_result(logic [nfba_pkg::GIVEN_W-1:0] given,
                               logic [nfba_pkg::STATUS_W-1:0] status,
                               logic [nfba_pkg::USED_W-1:0] used);
      grant_t g;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing awaited: given %0d status %0d used %0d",
                   $realtime, given, status, used);
      end else begin
        g = awaited.pop_front();
        if (given !== g.given || status !== g.status || used !== g.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: expected given %0d status %0d used %0d, ",
                      "got given %0d status %0d used %0d"},
                     $realtime, g.given, g.status, g.used, given, status, used);
        end
      end
    endfunction

    // Random slot that is occupied (or free); falls back to a random slot.
    function int unsigned pick_slot(bit want_taken);
      int unsigned start;
      int unsigned pos;
      start = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
        pos = (start + i) % SLOTS;
        if (taken[pos] == want_taken) return pos;
      end
      return start;
    endfunction
  endclass

  grant_book book;
  int        quiet;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor both channels at the rising edge: note accepted requests, check results,
  // and count cycles in which no word moves for the watchdog.
  always @(posedge clk) begin
    bit req_fire;
    bit res_fire;
    req_fire = req_ch.valid && req_ch.ready;
    res_fire = res_ch.valid && res_ch.ready;
    if (req_fire)
      book.note_request(nfba_pkg::action_t'(req_ch.action), req_ch.slot_to_free);
    if (res_fire) book.check_result(res_ch.given_slot, res_ch.status, res_ch.used_count);
    if (req_fire || res_fire) quiet <= 0;
    else quiet <= quiet + 1;
  end

  // Receiver: stall on a pattern that changes mode at random times -
  // always ready, scattered stalls, or long runs of stall and release.
  initial begin
    int mode;
    int tick;
    int run;
    bit level;
    res_ch.ready = 1'b0;
    mode  = 0;
    tick  = 0;
    run   = 0;
    level = 1'b1;
    forever begin
      @(negedge clk);
      if (tick == 0) begin
        mode = $urandom_range(0, 2);
        tick = $urandom_range(64, 400);
      end
      tick--;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run == 0) begin
            level = !level;
            run   = level ? $urandom_range(1, 8) : $urandom_range(1, 20);
          end
          run--;
          res_ch.ready <= level;
        end
      endcase
    end
  end

  // Offer one request word, hold it until accepted, then pace the sender: words go
  // out in bursts, and at the end of a burst valid drops for a random gap. Some
  // bursts get no gap at all, so back-to-back stretches occur too.
  task automatic offer(nfba_pkg::action_t act, int unsigned slot);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.slot_to_free <= nfba_pkg::REQ_SLOT_W'(slot);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid        <= 1'b0;
        req_ch.action       <= nfba_pkg::action_t'($urandom_range(0, 1));
        req_ch.slot_to_free <= nfba_pkg::REQ_SLOT_W'($urandom_range(0, 2047));
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Directed words: lowest slots, hint lowering on a free, double frees at both
  // ends of the range, out-of-range frees at both ends of the illegal range, and
  // an allocate carrying an all-ones slot field, which must be ignored.
  task automatic run_directed();
    offer(nfba_pkg::ACT_ALLOC, 0);
    offer(nfba_pkg::ACT_ALLOC, 0);
    offer(nfba_pkg::ACT_ALLOC, 0);
    offer(nfba_pkg::ACT_FREE, 1);
    offer(nfba_pkg::ACT_ALLOC, 0);
    offer(nfba_pkg::ACT_FREE, 1);
    offer(nfba_pkg::ACT_FREE, 1);
    offer(nfba_pkg::ACT_FREE, SLOTS);
    offer(nfba_pkg::ACT_FREE, 2047);
    offer(nfba_pkg::ACT_FREE, SLOTS - 1);
    offer(nfba_pkg::ACT_FREE, 0);
    offer(nfba_pkg::ACT_FREE, 2);
    offer(nfba_pkg::ACT_FREE, 0);
    offer(nfba_pkg::ACT_ALLOC, 2047);
    offer(nfba_pkg::ACT_ALLOC, 1024);
    offer(nfba_pkg::ACT_FREE, 0);
    offer(nfba_pkg::ACT_FREE, 1);
  endtask

  // Random words in three stages: fill the pool until it is full, churn around
  // the full mark so scans wrap and pool-full answers appear, then drain.
  // A few percent are noise: out-of-range frees and frees of free slots.
  task automatic run_random();
    int r;
    int alloc_pct;
    bit reached_full;
    reached_full = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (book.in_use == SLOTS) reached_full = 1'b1;
      if (!reached_full) alloc_pct = 97;
      else if (n < RANDOM_WORDS - DRAIN_WORDS) alloc_pct = 50;
      else alloc_pct = 12;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        if ($urandom_range(0, 1) == 0)
          offer(nfba_pkg::ACT_FREE, $urandom_range(SLOTS, 2047));
        else offer(nfba_pkg::ACT_FREE, book.pick_slot(1'b0));
      end else if (r < 3 + alloc_pct || book.in_use == 0) begin
        offer(nfba_pkg::ACT_ALLOC, $urandom_range(0, 2047));
      end else begin
        offer(nfba_pkg::ACT_FREE, book.pick_slot(1'b1));
      end
    end
  endtask

  initial begin
    bit timed_out;
    book                = new();
    quiet               = 0;
    timed_out           = 1'b0;
    burst_left          = 1;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.action       = nfba_pkg::ACT_ALLOC;
    req_ch.slot_to_free = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        run_directed();
        run_random();
        req_ch.valid <= 1'b0;
        // Wait for every awaited result, then wait out the settling period for
        // any stray word to show up.
        while (book.awaited.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      begin
        wait (quiet >= QUIET_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && book.mismatches == 0 && book.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
